// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HWF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hwf assertion failed");

// next-cycle implication, disabled during reset
`define HWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hwf assertion failed");

`endif

// ----- rtl/core/hwf_pkg.sv -----
// shared types, constants and the window coefficient table of the framer
package hwf_pkg;

    // frame and storage geometry
    localparam int FRAME_SIZE = 64;
    localparam int RING_DEPTH = 64;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int COUNT_W    = $clog2(FRAME_SIZE + 1);
    localparam int POS_W      = 6;
    localparam int SAMPLE_W   = 16;
    localparam int HOP_W      = 8;
    localparam int COEF_W     = 15;
    localparam int COEF_FRAC  = 14;
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [COEF_W-1:0]   coef_t;
    typedef logic        [POS_W-1:0]    pos_t;
    typedef logic        [ADDR_W-1:0]   addr_t;
    typedef logic        [HOP_W-1:0]    hop_t;
    typedef logic        [COUNT_W-1:0]  count_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    localparam hop_t  HOP_RESET  = hop_t'(32);
    localparam pos_t  LAST_POS   = pos_t'(FRAME_SIZE - 1);
    localparam prod_t ROUND_BIAS = prod_t'(1) <<< (COEF_FRAC - 1);

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // one issued frame position, from the sequencer to the multiply unit
    typedef struct packed {
        logic valid;
        pos_t pos;
        logic pad;
    } issue_t;

    // window table in q1.14, built at elaboration with q30 fixed-point arithmetic
    typedef coef_t win_rom_t [RING_DEPTH];

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;
    localparam logic [63:0] WIN_DEN = (FRAME_SIZE > 1) ? 64'(FRAME_SIZE - 1) : 64'd1;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    // taylor series of cosine, eight terms
    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = qmul(x, x);
        sum  = $signed(ONE_Q30);
        term = qmul(ONE_Q30, x2) / 64'd2;
        sum  = sum - $signed(term);
        term = qmul(term, x2) / 64'd12;
        sum  = sum + $signed(term);
        term = qmul(term, x2) / 64'd30;
        sum  = sum - $signed(term);
        term = qmul(term, x2) / 64'd56;
        sum  = sum + $signed(term);
        term = qmul(term, x2) / 64'd90;
        sum  = sum - $signed(term);
        term = qmul(term, x2) / 64'd132;
        sum  = sum + $signed(term);
        term = qmul(term, x2) / 64'd182;
        sum  = sum - $signed(term);
        return sum;
    endfunction

    // taylor series of sine, eight terms
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x2   = qmul(x, x);
        sum  = $signed(x);
        term = qmul(x, x2) / 64'd6;
        sum  = sum - $signed(term);
        term = qmul(term, x2) / 64'd20;
        sum  = sum + $signed(term);
        term = qmul(term, x2) / 64'd42;
        sum  = sum - $signed(term);
        term = qmul(term, x2) / 64'd72;
        sum  = sum + $signed(term);
        term = qmul(term, x2) / 64'd110;
        sum  = sum - $signed(term);
        term = qmul(term, x2) / 64'd156;
        sum  = sum + $signed(term);
        term = qmul(term, x2) / 64'd210;
        sum  = sum - $signed(term);
        return sum;
    endfunction

    // hamming coefficient in q1.14, octant reduction then series
    function automatic coef_t window_coef(input logic [63:0] j);
        logic [63:0] m;
        logic [63:0] p;
        logic        neg;
        longint      c;
        longint      val;
        m   = (j <= WIN_DEN - j) ? j : WIN_DEN - j;
        neg = 1'b0;
        if (4 * m <= WIN_DEN)
        begin
            p = 2 * m;
        end
        else
        begin
            p   = WIN_DEN - 2 * m;
            neg = 1'b1;
        end
        if (4 * p <= WIN_DEN)
        begin
            c = $signed(cos_q30((p * PI_Q30 + WIN_DEN / 2) / WIN_DEN));
        end
        else
        begin
            c = $signed(sin_q30(((WIN_DEN - 2 * p) * PI_Q30 + WIN_DEN) / (2 * WIN_DEN)));
        end
        if (neg)
        begin
            c = -c;
        end
        if (c > $signed(ONE_Q30))
        begin
            c = $signed(ONE_Q30);
        end
        if (c < -$signed(ONE_Q30))
        begin
            c = -$signed(ONE_Q30);
        end
        val = 54 * $signed(ONE_Q30) - 46 * c;
        return coef_t'((64'(val) + 64'd3276800) / 64'd6553600);
    endfunction

    function automatic win_rom_t build_window();
        win_rom_t rom;
        for (int j = 0; j < RING_DEPTH; j++)
        begin
            rom[j] = (j < FRAME_SIZE) ? window_coef(64'(j)) : '0;
        end
        return rom;
    endfunction

    localparam win_rom_t WIN_ROM = build_window();

endpackage

// ----- rtl/core/hwf_if.sv -----
// channel interfaces: sample items in, windowed items out, hop length writes
interface hwf_sample_if;
    import hwf_pkg::*;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last;
    modport source(output valid, sample, last, input ready);
    modport sink(input valid, sample, last, output ready);
endinterface

interface hwf_result_if;
    import hwf_pkg::*;
    logic    valid;
    logic    ready;
    sample_t windowed_value;
    pos_t    position;
    logic    frame_end;
    modport source(output valid, windowed_value, position, frame_end, input ready);
    modport sink(input valid, windowed_value, position, frame_end, output ready);
endinterface

interface hwf_cfg_if;
    import hwf_pkg::*;
    logic valid;
    logic ready;
    hop_t hop_length;
    modport source(output valid, hop_length, input ready);
    modport sink(input valid, hop_length, output ready);
endinterface

// ----- rtl/core/hwf_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module hwf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while disabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/hwf_ctrl.sv -----
// stream bookkeeping, frame decision and the per-position issue sequencer
module hwf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    hwf_sample_if.sink      samples,
    hwf_cfg_if.sink         cfg,
    input  logic            stall,
    output logic            wr_en,
    output hwf_pkg::addr_t  wr_addr,
    output hwf_pkg::sample_t wr_data,
    output hwf_pkg::addr_t  rd_addr,
    output hwf_pkg::issue_t issue
);
    import hwf_pkg::*;

    state_t           state_reg, state_next;
    addr_t            head_reg, head_next;
    count_t           seen_reg, seen_next;
    hop_t             phase_reg, phase_next;
    hop_t             hop_length_reg;
    addr_t            base_reg, base_next;
    count_t           real_reg, real_next;
    pos_t             pos_reg, pos_next;

    logic             accept;
    hop_t             hop_eff;
    count_t           seen_inc;
    logic             full;
    hop_t             tail_dist;
    logic             tail_go;
    logic             frame_go;
    count_t           frame_real;
    logic [HOP_W:0]   phase_inc;
    logic             issue_done;

    assign accept = samples.valid && samples.ready;

    // hop length register, always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_length_reg <= HOP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            hop_length_reg <= cfg.hop_length;
        end
    end

    // frame decision for the sample being accepted
    always_comb
    begin
        hop_eff    = (hop_length_reg == '0) ? hop_t'(1) : hop_length_reg;
        seen_inc   = (seen_reg < count_t'(FRAME_SIZE)) ? seen_reg + count_t'(1) : seen_reg;
        full       = (seen_inc == count_t'(FRAME_SIZE));
        tail_dist  = hop_eff - phase_reg;
        tail_go    = full && (phase_reg != '0) && (phase_reg < hop_eff)
                     && (tail_dist < hop_t'(FRAME_SIZE));
        phase_inc  = {1'b0, phase_reg} + (HOP_W + 1)'(1);
        frame_go   = 1'b0;
        frame_real = count_t'(FRAME_SIZE);
        if (full && (phase_reg == '0))
        begin
            frame_go = 1'b1;
        end
        else if (samples.last && !full)
        begin
            frame_go   = 1'b1;
            frame_real = seen_inc;
        end
        else if (samples.last && tail_go)
        begin
            frame_go   = 1'b1;
            frame_real = count_t'(FRAME_SIZE) - count_t'(tail_dist);
        end
    end

    assign issue_done = (state_reg == ST_RUN) && !stall && (pos_reg == LAST_POS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && frame_go)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        samples.ready = 1'b0;
        issue.valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
            end
            ST_RUN:
            begin
                issue.valid = 1'b1;
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
        issue.pos = pos_reg;
        issue.pad = (count_t'(pos_reg) >= real_reg);
        rd_addr   = base_reg + addr_t'(pos_reg);
    end

    // ring write of the accepted sample
    assign wr_en   = accept;
    assign wr_addr = head_reg;
    assign wr_data = samples.sample;

    // counters and frame window bounds
    always_comb
    begin
        head_next  = head_reg;
        seen_next  = seen_reg;
        phase_next = phase_reg;
        base_next  = base_reg;
        real_next  = real_reg;
        pos_next   = pos_reg;
        if (accept)
        begin
            if (samples.last)
            begin
                head_next  = '0;
                seen_next  = '0;
                phase_next = '0;
            end
            else
            begin
                head_next = head_reg + addr_t'(1);
                seen_next = seen_inc;
                if (full)
                begin
                    phase_next = (phase_inc >= {1'b0, hop_eff}) ? '0 : phase_inc[HOP_W-1:0];
                end
            end
            if (frame_go)
            begin
                base_next = head_reg + addr_t'(1) - frame_real[ADDR_W-1:0];
                real_next = frame_real;
                pos_next  = '0;
            end
        end
        else if ((state_reg == ST_RUN) && !stall)
        begin
            pos_next = pos_reg + pos_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            seen_reg  <= '0;
            phase_reg <= '0;
            base_reg  <= '0;
            real_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            seen_reg  <= seen_next;
            phase_reg <= phase_next;
            base_reg  <= base_next;
            real_reg  <= real_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

// ----- rtl/core/hwf_wmul.sv -----
// shared window multiplier: coefficient fetch, multiply, round, output register
module hwf_wmul (
    input  logic             clk,
    input  logic             rst_n,
    input  hwf_pkg::issue_t  issue,
    input  hwf_pkg::sample_t rd_data,
    output logic             stall,
    hwf_result_if.source     results
);
    import hwf_pkg::*;

    logic    s1_valid_reg;
    pos_t    s1_pos_reg;
    logic    s1_pad_reg;
    coef_t   s1_coef_reg;
    logic    s2_valid_reg;
    pos_t    s2_pos_reg;
    prod_t   prod_reg;
    logic    out_valid_reg;
    sample_t out_value_reg;
    pos_t    out_pos_reg;
    logic    out_end_reg;

    sample_t                mul_a;
    logic signed [COEF_W:0] mul_b;
    prod_t                  product;
    prod_t                  biased;

    // whole pipeline freezes while the output item waits
    assign stall = out_valid_reg && !results.ready;

    // multiply: padded positions use a zero sample
    always_comb
    begin
        mul_a   = s1_pad_reg ? '0 : rd_data;
        mul_b   = $signed({1'b0, s1_coef_reg});
        product = prod_t'(mul_a * mul_b);
        biased  = prod_reg + ROUND_BIAS;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg  <= issue.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // stage payloads; the ring read lands alongside stage one
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            s1_pos_reg    <= issue.pos;
            s1_pad_reg    <= issue.pad;
            s1_coef_reg   <= WIN_ROM[issue.pos];
            s2_pos_reg    <= s1_pos_reg;
            prod_reg      <= product;
            out_value_reg <= biased[SAMPLE_W+COEF_FRAC-1:COEF_FRAC];
            out_pos_reg   <= s2_pos_reg;
            out_end_reg   <= (s2_pos_reg == LAST_POS);
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.windowed_value = out_value_reg;
    assign results.position       = out_pos_reg;
    assign results.frame_end      = out_end_reg;

endmodule

// ----- rtl/core/hamming_window_framer.sv -----
// top level of the hamming-windowed overlapping framer
//
//   channel   dir   handshake       payload
//   samples   in    valid/ready     sample, last
//   results   out   valid/ready     windowed_value, position, frame_end
//   cfg       in    valid/ready     hop_length
//
// a sample item is taken only while idle; if it completes a frame the sequencer
// issues FRAME_SIZE positions, one per cycle unless stalled, through the single
// window multiplier while the input waits; results pass s1, s2 and an output stage
// the ring is read through one registered ram port, one sample per unstalled cycle
// reset clears the counters and sets hop_length to 32; the ring needs no clearing
// a stalled result freezes the issue counter, ram read and multiplier in place
module hamming_window_framer (
    input  logic        clk,
    input  logic        rst_n,
    hwf_sample_if.sink  samples,
    hwf_cfg_if.sink     cfg,
    hwf_result_if.source results
);
    import hwf_pkg::*;

    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
    addr_t   rd_addr;
    sample_t rd_data;
    issue_t  issue;
    logic    stall;

    // sequencer and stream state
    hwf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .stall   (stall),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .issue   (issue)
    );

    // sample ring
    hwf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (!stall),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // window multiply and output register
    hwf_wmul u_wmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .rd_data (rd_data),
        .stall   (stall),
        .results (results)
    );

endmodule

// ----- rtl/core/hwf_checker.sv -----
// port-level checker for the framer and its bind to the top level
`include "assert_macros.svh"

module hwf_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             samples_valid,
    input logic             samples_ready,
    input logic             results_valid,
    input logic             results_ready,
    input hwf_pkg::sample_t windowed_value,
    input hwf_pkg::pos_t    position,
    input logic             frame_end
);
    import hwf_pkg::*;

    logic prev_end_reg;
    pos_t prev_pos_reg;
    logic out_accept;

    assign out_accept = results_valid && results_ready;

    // last delivered position, to follow the frame sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_end_reg <= 1'b1;
            prev_pos_reg <= '0;
        end
        else if (out_accept)
        begin
            prev_end_reg <= frame_end;
            prev_pos_reg <= position;
        end
    end

    // input ready only drops right after an item was taken
    `HWF_ASSERT_IMPL(a_ready_falls_on_accept, clk, rst_n,
        $fell(samples_ready), $past(samples_valid))

    // a waiting result keeps its payload
    `HWF_ASSERT_NEXT(a_result_holds, clk, rst_n, results_valid && !results_ready,
        results_valid && $stable(windowed_value) && $stable(position) && $stable(frame_end))

    // positions run 0 up to the end of each frame without gaps
    `HWF_ASSERT_IMPL(a_position_sequence, clk, rst_n, out_accept,
        position == (prev_end_reg ? pos_t'(0) : prev_pos_reg + pos_t'(1)))

    // frame end marks exactly the last position
    `HWF_ASSERT_IMPL(a_frame_end_position, clk, rst_n, results_valid,
        frame_end == (position == LAST_POS))

endmodule

bind hamming_window_framer hwf_checker u_hwf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .samples_valid  (samples.valid),
    .samples_ready  (samples.ready),
    .results_valid  (results.valid),
    .results_ready  (results.ready),
    .windowed_value (results.windowed_value),
    .position       (results.position),
    .frame_end      (results.frame_end)
);

// ----- test/hamming_window_framer_test.sv -----
// self-checking testbench of the hamming window framer: sample streams under several hops
typedef struct {
    hwf_pkg::sample_t value;
    hwf_pkg::pos_t    position;
    logic             frame_end;
} windowed_value_t;

// predicts the windowed frames of a sample stream and checks the block's items against them
class windowed_frame_checker;
    windowed_value_t  pending_values[$];
    int               coef[hwf_pkg::FRAME_SIZE];
    hwf_pkg::sample_t ring[hwf_pkg::RING_DEPTH];
    int               head;
    int               seen;
    int               phase;
    hwf_pkg::hop_t    hop;
    int               errors;
    int               samples_taken;
    int               streams_done;
    int               full_frames;
    int               tail_frames;
    int               short_frames;
    int               values_checked;

    function new();
        real angle_step;
        real w;
        angle_step = 2.0 * 3.14159265358979323846
                     / ((hwf_pkg::FRAME_SIZE > 1) ? (hwf_pkg::FRAME_SIZE - 1) : 1);
        // hamming coefficients in q1.14, ties rounded upward
        for (int j = 0; j < hwf_pkg::FRAME_SIZE; j++)
        begin
            w = 16384.0 * (0.54 - 0.46 * $cos(angle_step * j));
            coef[j] = int'($floor(w + 0.5));
        end
        head           = 0;
        seen           = 0;
        phase          = 0;
        hop            = hwf_pkg::HOP_RESET;
        errors         = 0;
        samples_taken  = 0;
        streams_done   = 0;
        full_frames    = 0;
        tail_frames    = 0;
        short_frames   = 0;
        values_checked = 0;
    endfunction

    function void set_hop(hwf_pkg::hop_t value);
        hop = value;
    endfunction

    // queue one frame: the newest kept samples of the ring, then zeros
    function void emit_windowed_frame(int kept);
        windowed_value_t item;
        int              s;
        int              acc;
        for (int j = 0; j < hwf_pkg::FRAME_SIZE; j++)
        begin
            s = (j < kept) ? int'(ring[(head - kept + j) & (hwf_pkg::RING_DEPTH - 1)]) : 0;
            acc = (s * coef[j] + 8192) >>> 14;
            if (acc > 32767)
                acc = 32767;
            if (acc < -32768)
                acc = -32768;
            item.value     = hwf_pkg::sample_t'(acc);
            item.position  = hwf_pkg::pos_t'(j);
            item.frame_end = (j == hwf_pkg::FRAME_SIZE - 1);
            pending_values.push_back(item);
        end
    endfunction

    // one accepted sample item
    function void take_sample(hwf_pkg::sample_t s, logic fin);
        int span;
        int gap;
        bit full;
        span = (hop == 0) ? 1 : int'(hop);
        ring[head] = s;
        head = (head + 1) % hwf_pkg::RING_DEPTH;
        if (seen < hwf_pkg::FRAME_SIZE)
            seen++;
        full = (seen >= hwf_pkg::FRAME_SIZE);
        samples_taken++;
        if (full && phase == 0)
        begin
            emit_windowed_frame(hwf_pkg::FRAME_SIZE);
            full_frames++;
        end
        if (fin)
        begin
            // stream shorter than a frame, or a tail frame starting before the end
            if (!full)
            begin
                emit_windowed_frame(seen);
                short_frames++;
            end
            else if (phase != 0 && phase < span)
            begin
                gap = span - phase;
                if (gap < hwf_pkg::FRAME_SIZE)
                begin
                    emit_windowed_frame(hwf_pkg::FRAME_SIZE - gap);
                    tail_frames++;
                end
            end
            head  = 0;
            seen  = 0;
            phase = 0;
            streams_done++;
        end
        else if (full)
        begin
            phase = (phase + 1 >= span) ? 0 : phase + 1;
        end
    endfunction

    function void report(string field, int want_v, int got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endfunction

    // one accepted result item against the oldest prediction
    function void check_value(hwf_pkg::sample_t v, hwf_pkg::pos_t p, logic fe);
        windowed_value_t want;
        if (pending_values.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected item, expected none, got value %0d position %0d",
                     $time, v, p);
            return;
        end
        want = pending_values.pop_front();
        values_checked++;
        if (v !== want.value)
            report("windowed_value", int'(want.value), int'(v));
        if (p !== want.position)
            report("position", int'(want.position), int'(p));
        if (fe !== want.frame_end)
            report("frame_end", int'(want.frame_end), int'(fe));
    endfunction
endclass

module hamming_window_framer_test;
    import hwf_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int TARGET_ITEMS  = 410;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   hold_requests = 0;
    int   burst_left    = 0;

    windowed_frame_checker frames;

    hwf_sample_if samples ();
    hwf_cfg_if    cfg ();
    hwf_result_if results ();

    hamming_window_framer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .results (results)
    );

    // clock, period 20
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
            frames.check_value(results.windowed_value, results.position, results.frame_end);
    end

    // receiver: spans of steady, random or periodic ready, plus requested long hold-offs
    initial
    begin : result_sink
        int hold_served;
        int span;
        int mode;
        int period;
        int tick;
        hold_served   = 0;
        tick          = 0;
        results.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    results.ready <= 1'b0;
                end
            end
            span   = $urandom_range(4, 40);
            mode   = $urandom_range(0, 3);
            period = $urandom_range(2, 4);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0: results.ready <= 1'b1;
                    1: results.ready <= ($urandom_range(0, 3) != 0);
                    2: results.ready <= ((tick % period) == 0);
                    default: results.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    function automatic sample_t random_sample();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic hop_t pick_hop();
        case ($urandom_range(0, 9))
            0: return 8'd1;
            1: return 8'd2;
            2: return 8'd255;
            3: return 8'd0;
            4: return 8'd64;
            5: return 8'd63;
            6: return 8'd65;
            default: return hop_t'($urandom_range(3, 128));
        endcase
    endfunction

    // offer one sample item, in bursts with gaps; called and returns at a falling edge
    task automatic send_sample(sample_t value, logic fin);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                samples.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        samples.valid  <= 1'b1;
        samples.sample <= value;
        samples.last   <= fin;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        frames.take_sample(value, fin);
        burst_left--;
        @(negedge clk);
    endtask

    // hop write once every predicted item has come and the block has settled
    task automatic write_hop(hop_t value);
        samples.valid <= 1'b0;
        while (frames.pending_values.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg.valid      <= 1'b1;
        cfg.hop_length <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        frames.set_hop(value);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // one stream of random samples, optionally rewriting the hop partway through
    task automatic run_stream(int len, int change_at, hop_t next_hop);
        for (int i = 0; i < len; i++)
        begin
            if (i == change_at)
                write_hop(next_hop);
            send_sample(random_sample(), i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        sample_t corner_samples [7];
        int      stream_no;
        int      len;
        int      change_at;
        int      pick;
        frames = new();
        samples.valid  = 1'b0;
        samples.sample = '0;
        samples.last   = 1'b0;
        cfg.valid      = 1'b0;
        cfg.hop_length = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // lone full-scale sample, then a short stream of corner values
        send_sample(16'h7FFF, 1'b1);
        corner_samples = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001,
                           16'h5555, 16'hAAAA, 16'h7FFF};
        foreach (corner_samples[k])
            send_sample(corner_samples[k], k == 6);

        // largest hop: exactly one frame, no tail
        write_hop(8'd255);
        run_stream(FRAME_SIZE, -1, '0);

        // zero hop acts as one; the receiver holds off so the block backs up
        write_hop(8'd0);
        hold_requests++;
        run_stream(FRAME_SIZE + 2, -1, '0);

        // reset hop with a padded tail frame
        write_hop(HOP_RESET);
        run_stream(90, -1, '0);

        // hop shrinks right before the last sample, phase left past the new hop
        write_hop(8'd8);
        run_stream(71, 70, 8'd3);

        // random streams with random hops and lengths
        stream_no = 0;
        while (frames.samples_taken < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (stream_no == 0)
                len = FRAME_SIZE - 1;
            else if (pick < 2)
                len = $urandom_range(1, FRAME_SIZE - 1);
            else if (pick == 2)
                len = $urandom_range(FRAME_SIZE, 2 * FRAME_SIZE + 40);
            else
                len = $urandom_range(FRAME_SIZE, FRAME_SIZE + 70);
            // keep the total close to the target count
            if (len > TARGET_ITEMS - frames.samples_taken)
                len = TARGET_ITEMS - frames.samples_taken;
            if (stream_no == 0 || $urandom_range(0, 9) < 6)
                write_hop(pick_hop());
            change_at = (len > FRAME_SIZE && $urandom_range(0, 9) == 0)
                        ? $urandom_range(FRAME_SIZE, len - 1) : -1;
            run_stream(len, change_at, pick_hop());
            stream_no++;
        end

        // drain
        samples.valid <= 1'b0;
        while (frames.pending_values.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES * 4) @(negedge clk);

        $display("run covered %0d samples in %0d streams: %0d full, %0d tail, %0d short frames",
                 frames.samples_taken, frames.streams_done, frames.full_frames,
                 frames.tail_frames, frames.short_frames);
        $display("%0d windowed values checked, hops 0 to 255, stalls and hold-offs on both sides",
                 frames.values_checked);
        if (frames.errors == 0 && frames.pending_values.size() == 0)
            $display("hamming_window_framer_test: PASS");
        else
            $display("hamming_window_framer_test: FAIL");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #20000000;
        $display("hamming_window_framer_test: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/hwf_pkg.sv
rtl/core/hwf_if.sv
rtl/core/hwf_ram.sv
rtl/core/hwf_ctrl.sv
rtl/core/hwf_wmul.sv
rtl/core/hamming_window_framer.sv
rtl/core/hwf_checker.sv
test/hamming_window_framer_test.sv
